[sv/ftprlf_pkg.sv]
package ftprlf_pkg;

	// control characters and reply digits
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_ONE = 8'h31;
	localparam logic [7:0] CH_THREE = 8'h33;

	localparam int LIMIT_W = 12;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2049;

	// one result beat
	typedef struct packed {
		logic [7:0] chr;
		logic       valid;
		logic       line_end;
		logic       reply_end;
		logic [7:0] lead;
		logic       err;
		logic       last;
	} res_t;

	// all results caused by one byte, in order
	typedef struct packed {
		logic [1:0] count;
		res_t       res0;
		res_t       res1;
	} step_t;

endpackage

[sv/ftprlf_line_track.sv]
module ftprlf_line_track (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ftprlf_pkg::LIMIT_W-1:0] cfg_data,
	input  logic                          fire,
	input  logic [7:0]                    rx_byte,
	output ftprlf_pkg::step_t             step
);

	logic [ftprlf_pkg::LIMIT_W-1:0] limit_q;
	logic                           prev_cr_q;
	logic                           cr_held_q;
	logic [ftprlf_pkg::LIMIT_W-1:0] line_len_q;
	logic                           in_first_q;
	logic [23:0]                    first_code_q;
	logic                           first_long_q;
	logic [31:0]                    line_head_q;

	logic                           lf_end;
	logic                           is_nul;
	logic                           is_cr;
	logic                           store;
	logic [ftprlf_pkg::LIMIT_W-1:0] stripped;
	logic [7:0]                     fourth;
	logic                           over;
	logic [7:0]                     lead;
	logic                           err;
	logic [31:0]                    head_n;
	ftprlf_pkg::res_t               r_end;
	ftprlf_pkg::res_t               r_cr;
	ftprlf_pkg::res_t               r_chr;

	// byte classification
	assign is_nul = (rx_byte == ftprlf_pkg::CH_NUL);
	assign is_cr = (rx_byte == ftprlf_pkg::CH_CR);
	assign lf_end = (rx_byte == ftprlf_pkg::CH_LF) && prev_cr_q;
	assign store = !lf_end && !is_nul && (line_len_q < limit_q);

	// line end judgement
	assign stripped = line_len_q - {{(ftprlf_pkg::LIMIT_W-1){1'b0}}, cr_held_q};
	assign fourth = line_head_q[31:24];

	always_comb begin
		if (in_first_q) begin
			over = (stripped < 12'd4) || (fourth == ftprlf_pkg::CH_SP);
			lead = (stripped != '0) ? line_head_q[7:0] : 8'h00;
		end else begin
			over = !first_long_q ||
				((fourth == ftprlf_pkg::CH_SP) && (line_head_q[23:0] == first_code_q));
			lead = first_code_q[7:0];
		end
		if (!over) begin
			lead = 8'h00;
		end
		err = over && ((lead < ftprlf_pkg::CH_ONE) || (lead > ftprlf_pkg::CH_THREE));
	end

	// head bytes of the current line
	always_comb begin
		head_n = line_head_q;
		for (int i = 0; i < 4; i++) begin
			if (line_len_q == 12'(i)) begin
				head_n[8*i +: 8] = rx_byte;
			end
		end
	end

	// result beats
	always_comb begin
		r_end = '0;
		r_end.line_end = 1'b1;
		r_end.reply_end = over;
		r_end.lead = lead;
		r_end.err = err;
		r_end.last = 1'b1;

		r_cr = '0;
		r_cr.chr = ftprlf_pkg::CH_CR;
		r_cr.valid = 1'b1;
		r_cr.last = is_cr;

		r_chr = '0;
		r_chr.chr = rx_byte;
		r_chr.valid = 1'b1;
		r_chr.last = 1'b1;

		step = '0;
		if (lf_end) begin
			step.count = 2'd1;
			step.res0 = r_end;
		end else if (store) begin
			if (cr_held_q) begin
				step.res0 = r_cr;
				step.res1 = r_chr;
				step.count = is_cr ? 2'd1 : 2'd2;
			end else if (!is_cr) begin
				step.res0 = r_chr;
				step.count = 2'd1;
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ftprlf_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	// line and reply state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cr_q <= 1'b0;
			cr_held_q <= 1'b0;
			line_len_q <= '0;
			in_first_q <= 1'b1;
			first_code_q <= '0;
			first_long_q <= 1'b0;
			line_head_q <= '0;
		end else if (fire) begin
			if (lf_end) begin
				prev_cr_q <= 1'b0;
				cr_held_q <= 1'b0;
				line_len_q <= '0;
				line_head_q <= '0;
				if (over) begin
					in_first_q <= 1'b1;
					first_code_q <= '0;
					first_long_q <= 1'b0;
				end else if (in_first_q) begin
					in_first_q <= 1'b0;
					first_code_q <= line_head_q[23:0];
					first_long_q <= 1'b1;
				end
			end else if (is_nul) begin
				prev_cr_q <= 1'b0;
			end else begin
				prev_cr_q <= is_cr;
				if (store) begin
					line_head_q <= head_n;
					line_len_q <= line_len_q + 12'd1;
					cr_held_q <= is_cr;
				end
			end
		end
	end

endmodule

[sv/ftp_reply_line_framer_core.sv]
// channel  | handshake              | payload
// rx       | rx_valid / rx_ready    | rx_byte
// out      | out_valid / out_ready  | out_byte, byte_valid, line_end, reply_end,
//          |                        | reply_lead, reply_error, last_of_run
// cfg      | cfg_valid / cfg_ready  | cfg_data (line_char_limit)
//
// one byte per cycle unless the output stalls: input register, then one pass
// of compare logic into the output register; a two-beat byte (held cr plus a
// character) holds off the next byte till both beats leave the single output port
// arst_n clears all control state, limit resets to 2049
// a stalled output holds its beat while one more byte waits in the input register
// cfg_ready is always high
module ftp_reply_line_framer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        line_end,
	output logic        reply_end,
	output logic [7:0]  reply_lead,
	output logic        reply_error,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              fire;
	logic              can_take;
	logic              out_valid_q;
	ftprlf_pkg::res_t  out_q;
	logic              pend_valid_q;
	ftprlf_pkg::res_t  pend_q;
	ftprlf_pkg::step_t step;

	assign cfg_ready = 1'b1;

	// queue must be free after this cycle before a byte is processed
	assign can_take = !pend_valid_q && (!out_valid_q || out_ready);
	assign fire = valid_s1 && can_take;
	assign rx_ready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && rx_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	ftprlf_line_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.fire    (fire),
		.rx_byte (byte_s1),
		.step    (step)
	);

	// output register and pending second beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (fire && (step.count != 2'd0)) begin
			out_valid_q <= 1'b1;
			pend_valid_q <= (step.count == 2'd2);
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (step.count != 2'd0)) begin
			out_q <= step.res0;
			pend_q <= step.res1;
		end else if (out_valid_q && out_ready && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_q.chr;
	assign byte_valid = out_q.valid;
	assign line_end = out_q.line_end;
	assign reply_end = out_q.reply_end;
	assign reply_lead = out_q.lead;
	assign reply_error = out_q.err;
	assign last_of_run = out_q.last;

`ifndef SYNTHESIS
	// a pending beat always sits behind a shown one
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("pending beat without output beat");

	// a byte is never processed over a pending beat
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !fire)
		else $error("byte processed while second beat pending");

	// a two-beat byte leaves its second beat pending
	a_pair_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (step.count == 2'd2)) |=> (pend_valid_q && out_valid_q && !last_of_run))
		else $error("second beat of a pair lost");
`endif

endmodule

[test/ftp_reply_line_framer_core_test.sv]
module ftp_reply_line_framer_core_test;

	localparam int QUIET_LIMIT = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS = 40;

	logic clk;
	logic arst_n;
	logic rx_valid;
	logic rx_ready;
	logic [7:0] rx_byte;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;
	logic byte_valid;
	logic line_end;
	logic reply_end;
	logic [7:0] reply_lead;
	logic reply_error;
	logic last_of_run;
	logic cfg_valid;
	logic cfg_ready;
	logic [11:0] cfg_data;

	// framer state as predicted
	logic [11:0] char_limit;
	logic saw_cr;
	logic cr_pending;
	logic [11:0] line_len;
	logic first_line;
	logic [23:0] lead_code;
	logic long_first;
	logic [31:0] head_chars;

	ftprlf_pkg::res_t pending_beats [$];

	bit idle_on = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;
	int fail_count = 0;
	int bytes_sent = 0;
	int beats_checked = 0;
	int lines_seen = 0;
	int replies_seen = 0;

	ftp_reply_line_framer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.line_end(line_end),
		.reply_end(reply_end),
		.reply_lead(reply_lead),
		.reply_error(reply_error),
		.last_of_run(last_of_run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// clear the per-line state
	task automatic clear_line_state();
		saw_cr = 1'b0;
		cr_pending = 1'b0;
		line_len = '0;
		head_chars = '0;
	endtask

	task automatic reset_framer_state();
		char_limit = ftprlf_pkg::LIMIT_RESET;
		clear_line_state();
		first_line = 1'b1;
		lead_code = '0;
		long_first = 1'b0;
	endtask

	// predict the beats caused by one received byte
	task automatic frame_byte(input logic [7:0] ch);
		ftprlf_pkg::res_t beat [2];
		int n;
		logic [11:0] kept;
		logic done;
		logic [7:0] lead;
		n = 0;
		beat[0] = '0;
		beat[1] = '0;
		if (ch == ftprlf_pkg::CH_LF && saw_cr) begin
			// line end: judge whether the reply is complete
			kept = line_len - {11'd0, cr_pending};
			lead = 8'h00;
			if (first_line) begin
				done = (kept <= 12'd3) || (head_chars[31:24] == ftprlf_pkg::CH_SP);
				if (done) begin
					lead = (kept > 12'd0) ? head_chars[7:0] : 8'h00;
				end else begin
					lead_code = head_chars[23:0];
					long_first = 1'b1;
					first_line = 1'b0;
				end
			end else begin
				done = !long_first ||
					(head_chars[31:24] == ftprlf_pkg::CH_SP && head_chars[23:0] == lead_code);
				if (done)
					lead = lead_code[7:0];
			end
			beat[0].line_end = 1'b1;
			beat[0].reply_end = done;
			if (done) begin
				beat[0].lead = lead;
				beat[0].err = (lead < ftprlf_pkg::CH_ONE) || (lead > ftprlf_pkg::CH_THREE);
				first_line = 1'b1;
				lead_code = '0;
				long_first = 1'b0;
			end
			n = 1;
			clear_line_state();
		end else if (ch == ftprlf_pkg::CH_NUL) begin
			saw_cr = 1'b0;
		end else begin
			// stored or dropped character
			saw_cr = (ch == ftprlf_pkg::CH_CR);
			if (line_len < char_limit) begin
				if (line_len < 12'd4)
					head_chars[8 * line_len[1:0] +: 8] = ch;
				line_len = line_len + 12'd1;
				if (cr_pending) begin
					beat[n].chr = ftprlf_pkg::CH_CR;
					beat[n].valid = 1'b1;
					n++;
				end
				if (ch == ftprlf_pkg::CH_CR) begin
					cr_pending = 1'b1;
				end else begin
					cr_pending = 1'b0;
					beat[n].chr = ch;
					beat[n].valid = 1'b1;
					n++;
				end
			end
		end
		if (n > 0)
			beat[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_beats = {pending_beats, beat[i]};
	endtask

	// send one byte; called at a falling edge, returns at a falling edge
	task automatic send_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!rx_ready);
		frame_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// hold the sender until every predicted beat has come out
	task automatic wait_drained();
		rx_valid <= 1'b0;
		do @(negedge clk); while (pending_beats.size() != 0);
	endtask

	task automatic settle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [11:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		char_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] text_char();
		logic [7:0] b;
		if ($urandom_range(0, 7) == 0) begin
			b = 8'($urandom_range(0, 255));
			if (b == ftprlf_pkg::CH_CR || b == ftprlf_pkg::CH_LF)
				b = ftprlf_pkg::CH_SP;
		end else begin
			b = 8'($urandom_range(8'h20, 8'h7E));
		end
		return b;
	endfunction

	task automatic send_text(input int len);
		repeat (len) send_byte(text_char());
	endtask

	function automatic int text_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
	endfunction

	// line terminator, sometimes broken or doubled
	task automatic send_eol();
		case ($urandom_range(0, 9))
			0: begin
				send_byte(ftprlf_pkg::CH_CR);
				send_byte(ftprlf_pkg::CH_NUL);
				send_byte(ftprlf_pkg::CH_LF);
				send_byte(ftprlf_pkg::CH_CR);
				send_byte(ftprlf_pkg::CH_LF);
			end
			1: begin
				send_byte(ftprlf_pkg::CH_CR);
				send_byte(ftprlf_pkg::CH_CR);
				send_byte(ftprlf_pkg::CH_LF);
			end
			default: begin
				send_byte(ftprlf_pkg::CH_CR);
				send_byte(ftprlf_pkg::CH_LF);
			end
		endcase
	endtask

	task automatic send_code(input logic [23:0] code, input logic [7:0] sep);
		send_byte(code[7:0]);
		send_byte(code[15:8]);
		send_byte(code[23:16]);
		send_byte(sep);
	endtask

	// one reply with random content, mostly well formed
	task automatic send_reply();
		logic [23:0] code;
		code[7:0] = ($urandom_range(0, 7) == 0) ? text_char() : 8'($urandom_range(8'h30, 8'h36));
		code[15:8] = 8'($urandom_range(8'h30, 8'h39));
		code[23:16] = 8'($urandom_range(8'h30, 8'h39));
		case ($urandom_range(0, 9))
			0: begin
				// short first line ends the reply
				send_text($urandom_range(0, 3));
				send_eol();
			end
			1: begin
				send_code(code, ftprlf_pkg::CH_SP);
				send_text(text_len());
				send_eol();
			end
			default: begin
				// multi-line reply
				send_code(code, "-");
				send_text(text_len());
				send_eol();
				repeat ($urandom_range(0, 3)) begin
					case ($urandom_range(0, 3))
						0: send_code(code, "-");
						1: send_code(code ^ 24'h010000, ftprlf_pkg::CH_SP);
						default: ;
					endcase
					send_text(text_len());
					send_eol();
				end
				send_code(code, ftprlf_pkg::CH_SP);
				send_text(text_len());
				send_eol();
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// receiver stall bursts
	always @(negedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (idle_on && $urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 13);
		out_ready <= (stall_left == 0);
	end

	// compare each output beat with the oldest prediction
	always @(posedge clk) begin
		ftprlf_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: unexpected beat, expected none, actual byte %0h end %0b",
						$time, out_byte, line_end);
			end else begin
				want = pending_beats.pop_front();
				check_field("out_byte", want.chr, out_byte);
				check_field("byte_valid", {7'd0, want.valid}, {7'd0, byte_valid});
				check_field("line_end", {7'd0, want.line_end}, {7'd0, line_end});
				check_field("reply_end", {7'd0, want.reply_end}, {7'd0, reply_end});
				check_field("reply_lead", want.lead, reply_lead);
				check_field("reply_error", {7'd0, want.err}, {7'd0, reply_error});
				check_field("last_of_run", {7'd0, want.last}, {7'd0, last_of_run});
				beats_checked++;
				if (want.line_end)
					lines_seen++;
				if (want.reply_end)
					replies_seen++;
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((rx_valid && rx_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d predictions outstanding",
				$time, quiet_cycles, pending_beats.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// extremes and special cases at the reset limit
	task automatic test_reset_defaults();
		logic [7:0] seq [21];
		seq = '{ftprlf_pkg::CH_NUL, 8'hFF, ftprlf_pkg::CH_CR, ftprlf_pkg::CH_NUL,
			ftprlf_pkg::CH_LF, ftprlf_pkg::CH_CR, ftprlf_pkg::CH_LF,
			"2", "1", "0", "-", ftprlf_pkg::CH_CR, ftprlf_pkg::CH_LF,
			"2", "1", "0", ftprlf_pkg::CH_SP, ftprlf_pkg::CH_CR, ftprlf_pkg::CH_LF,
			ftprlf_pkg::CH_CR, ftprlf_pkg::CH_LF};
		foreach (seq[i])
			send_byte(seq[i]);
		settle();
	endtask

	task automatic test_replies(input logic [11:0] limit, input int nbytes);
		int stop_at;
		write_limit(limit);
		stop_at = bytes_sent + nbytes;
		while (bytes_sent < stop_at) begin
			send_reply();
			if ($urandom_range(0, 19) == 0)
				wait_drained();
		end
		settle();
	endtask

	// random bytes, rich in control characters
	task automatic test_noise(input int nbytes);
		write_limit(12'($urandom_range(4, 8)));
		repeat (nbytes) begin
			case ($urandom_range(0, 7))
				0: send_byte(ftprlf_pkg::CH_CR);
				1: send_byte(ftprlf_pkg::CH_LF);
				2: send_byte(ftprlf_pkg::CH_NUL);
				default: send_byte(8'($urandom_range(0, 255)));
			endcase
		end
		settle();
	endtask

	task automatic test_full_rate(input int nbytes);
		int stop_at;
		idle_on = 1'b0;
		write_limit(12'($urandom_range(4, 16)));
		stop_at = bytes_sent + nbytes;
		while (bytes_sent < stop_at)
			send_reply();
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_byte = 8'h00;
		cfg_valid = 1'b0;
		cfg_data = '0;
		reset_framer_state();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_replies(12'd4, 220);
		test_replies(12'd4095, 220);
		test_replies(12'($urandom_range(5, 12)), 220);
		test_replies(12'($urandom_range(13, 64)), 200);
		test_replies(12'($urandom_range(4, 4095)), 200);
		test_noise(150);
		test_full_rate(180);

		if (pending_beats.size() != 0) begin
			fail_count++;
			$display("%0t: %0d predicted beats never came", $time, pending_beats.size());
		end
		$display("covered %0d bytes, %0d beats, %0d line ends, %0d reply ends",
			bytes_sent, beats_checked, lines_seen, replies_seen);
		$display("limits: reset value, 4, 4095 and random; random stalls, then full rate");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[sim.f]
sv/ftprlf_pkg.sv
sv/ftprlf_line_track.sv
sv/ftp_reply_line_framer_core.sv
test/ftp_reply_line_framer_core_test.sv
